// ----- rtl/rspd_pkg.sv -----
package rspd_pkg;

  // one byte of a sprite record
  typedef struct packed {
    logic [7:0] data_byte;
    logic       record_start;
  } rspd_in_t;

  // one pixel run
  typedef struct packed {
    logic [9:0]  position;
    logic [10:0] run_length;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        sprite_done;
  } rspd_out_t;

  // runs produced by one byte, second only together with the first
  typedef struct packed {
    logic      push_a;
    logic      push_b;
    rspd_out_t run_a;
    rspd_out_t run_b;
  } rspd_emit_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_SKIP,
    PH_SIZE_LO,
    PH_SIZE_HI,
    PH_T_LO,
    PH_T_HI,
    PH_C_LO,
    PH_C_HI,
    PH_RED,
    PH_GREEN,
    PH_BLUE
  } phase_t;

  localparam int BC_W = 18;
  localparam logic [BC_W-1:0] CHUNK_HDR_BYTES = 18'd4;
  localparam logic [BC_W-1:0] PIXEL_BYTES     = 18'd3;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

endpackage

// ----- rtl/rle_sprite_pixel_decoder_unit.sv -----
// channel | ports                          | carries
// in      | in_valid in_stall in_data      | one record byte, record_start on first
// out     | out_valid out_stall out_data   | one pixel run: position, length, rgba
//
// one byte per cycle while out_stall stays low; a taken byte waits in the input
// register until the run queue has room, and its runs reach out through that queue
// a byte that closes the sprite data yields two runs and holds in while the
// three-entry run queue drains
// in_stall comes only from the input register and the queue fill level, so no
// combinational path runs from out_stall to in_stall
// synchronous active-low reset empties both stages and parks the decoder idle
module rle_sprite_pixel_decoder_unit #(
  parameter int PIXELS_PER_SPRITE = 1024,
  parameter int HEADER_SKIP       = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rspd_pkg::rspd_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rspd_pkg::rspd_out_t out_data
);

  // input register
  logic                in_v_r, in_v_nxt;
  rspd_pkg::rspd_in_t  in_q_r;
  logic                in_take;

  // decode step and run queue
  logic                 step;
  logic                 q_room;
  logic                 pop;
  rspd_pkg::rspd_emit_t emit;

  // the held byte decodes as soon as the queue can take two runs
  assign step     = in_v_r && q_room;
  assign in_stall = in_v_r && !q_room;
  assign in_take  = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_take) begin
      in_v_nxt = 1'b1;
    end else if (step) begin
      in_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) in_q_r <= in_data;
  end

  // byte parser, counters and run generation
  rspd_core #(
    .PIXELS_PER_SPRITE (PIXELS_PER_SPRITE),
    .HEADER_SKIP       (HEADER_SKIP)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (in_q_r),
    .emit  (emit)
  );

  // registered run queue feeding the out port
  rspd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit      (emit),
    .pop       (pop),
    .head      (out_data),
    .not_empty (out_valid),
    .has_room  (q_room)
  );

  a_step_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !in_take) |=> !in_v_r)
    else $error("decoded byte left in input register");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> in_v_r)
    else $error("input register lost a stalled byte");

  a_runs_need_step: assert property (@(posedge clk) disable iff (!rst_n)
    (emit.push_a || emit.push_b) |-> step)
    else $error("run produced without a decode step");

endmodule

// ----- rtl/rspd_core.sv -----
module rspd_core #(
  parameter int PIXELS_PER_SPRITE = 1024,
  parameter int HEADER_SKIP       = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  rspd_pkg::rspd_in_t   item,
  output rspd_pkg::rspd_emit_t emit
);

  localparam int WPW = $clog2(PIXELS_PER_SPRITE + 1);
  localparam logic [WPW-1:0] PIX_W = WPW'(PIXELS_PER_SPRITE);
  localparam logic [1:0] SKIP_W = 2'(HEADER_SKIP);
  localparam rspd_pkg::phase_t START_PH =
    (HEADER_SKIP > 0) ? rspd_pkg::PH_SKIP : rspd_pkg::PH_SIZE_LO;

  rspd_pkg::phase_t phase_r, phase_nxt, ph_e;
  logic [1:0]                skip_r, skip_nxt, skip_e, skip_inc;
  logic [15:0]               ds_r, ds_nxt, ds_e;
  logic [rspd_pkg::BC_W-1:0] bc_r, bc_nxt, bc_e, bc4, bc3;
  logic [WPW-1:0]            wp_r, wp_nxt, wp_e, wp1, room, tc, t_end;
  logic [15:0]               crem_r, crem_nxt, crem_e, crem_dec;
  logic [7:0]                lo_r, lo_nxt, red_r, red_nxt, grn_r, grn_nxt;
  logic [15:0]               word;
  logic                      end4, end3;

  function automatic rspd_pkg::rspd_out_t mk_run(
    input logic [WPW-1:0] pos,
    input logic [WPW-1:0] len,
    input logic [7:0]     r,
    input logic [7:0]     g,
    input logic [7:0]     b,
    input logic [7:0]     a,
    input logic           done
  );
    rspd_pkg::rspd_out_t o;
    o.position    = 10'(pos);
    o.run_length  = 11'(len);
    o.red         = r;
    o.green       = g;
    o.blue        = b;
    o.alpha       = a;
    o.sprite_done = done;
    return o;
  endfunction

  // record start restarts decoding with this very byte
  assign ph_e   = item.record_start ? START_PH : phase_r;
  assign skip_e = item.record_start ? 2'd0 : skip_r;
  assign ds_e   = item.record_start ? 16'd0 : ds_r;
  assign bc_e   = item.record_start ? '0 : bc_r;
  assign wp_e   = item.record_start ? '0 : wp_r;
  assign crem_e = item.record_start ? 16'd0 : crem_r;

  assign word     = {item.data_byte, lo_r};
  assign skip_inc = skip_e + 2'd1;
  assign room     = PIX_W - wp_e;
  assign tc       = (word > 16'(room)) ? room : WPW'(word);
  assign t_end    = wp_e + tc;
  assign wp1      = wp_e + WPW'(1);
  assign bc4      = bc_e + rspd_pkg::CHUNK_HDR_BYTES;
  assign bc3      = bc_e + rspd_pkg::PIXEL_BYTES;
  assign end4     = bc4 >= rspd_pkg::BC_W'(ds_e);
  assign end3     = bc3 >= rspd_pkg::BC_W'(ds_e);
  assign crem_dec = crem_e - 16'd1;

  // next state
  always_comb begin
    phase_nxt = ph_e;
    skip_nxt  = skip_e;
    ds_nxt    = ds_e;
    bc_nxt    = bc_e;
    wp_nxt    = wp_e;
    crem_nxt  = crem_e;
    lo_nxt    = lo_r;
    red_nxt   = red_r;
    grn_nxt   = grn_r;
    case (ph_e)
      rspd_pkg::PH_SKIP: begin
        skip_nxt = skip_inc;
        if (skip_inc >= SKIP_W) phase_nxt = rspd_pkg::PH_SIZE_LO;
      end
      rspd_pkg::PH_SIZE_LO: begin
        lo_nxt    = item.data_byte;
        phase_nxt = rspd_pkg::PH_SIZE_HI;
      end
      rspd_pkg::PH_SIZE_HI: begin
        ds_nxt = word;
        bc_nxt = '0;
        if (word == 16'd0) begin
          wp_nxt    = PIX_W;
          phase_nxt = rspd_pkg::PH_IDLE;
        end else begin
          phase_nxt = rspd_pkg::PH_T_LO;
        end
      end
      rspd_pkg::PH_T_LO: begin
        lo_nxt    = item.data_byte;
        phase_nxt = rspd_pkg::PH_T_HI;
      end
      rspd_pkg::PH_C_LO: begin
        lo_nxt    = item.data_byte;
        phase_nxt = rspd_pkg::PH_C_HI;
      end
      rspd_pkg::PH_T_HI: begin
        wp_nxt    = t_end;
        phase_nxt = (t_end >= PIX_W) ? rspd_pkg::PH_IDLE : rspd_pkg::PH_C_LO;
      end
      rspd_pkg::PH_C_HI: begin
        crem_nxt = word;
        bc_nxt   = bc4;
        if (word != 16'd0) begin
          phase_nxt = rspd_pkg::PH_RED;
        end else if (end4) begin
          wp_nxt    = PIX_W;
          phase_nxt = rspd_pkg::PH_IDLE;
        end else begin
          phase_nxt = rspd_pkg::PH_T_LO;
        end
      end
      rspd_pkg::PH_RED: begin
        red_nxt   = item.data_byte;
        phase_nxt = rspd_pkg::PH_GREEN;
      end
      rspd_pkg::PH_GREEN: begin
        grn_nxt   = item.data_byte;
        phase_nxt = rspd_pkg::PH_BLUE;
      end
      rspd_pkg::PH_BLUE: begin
        bc_nxt   = bc3;
        crem_nxt = crem_dec;
        wp_nxt   = wp1;
        if (wp1 >= PIX_W) begin
          phase_nxt = rspd_pkg::PH_IDLE;
        end else if (crem_dec != 16'd0) begin
          phase_nxt = rspd_pkg::PH_RED;
        end else if (end3) begin
          wp_nxt    = PIX_W;
          phase_nxt = rspd_pkg::PH_IDLE;
        end else begin
          phase_nxt = rspd_pkg::PH_T_LO;
        end
      end
      default: phase_nxt = rspd_pkg::PH_IDLE;
    endcase
  end

  // runs out
  always_comb begin
    emit = '0;
    case (ph_e)
      rspd_pkg::PH_SIZE_HI: begin
        if (word == 16'd0 && wp_e < PIX_W) begin
          emit.push_a = 1'b1;
          emit.run_a  = mk_run(wp_e, PIX_W - wp_e, 8'd0, 8'd0, 8'd0,
                               rspd_pkg::ALPHA_CLEAR, 1'b1);
        end
      end
      rspd_pkg::PH_T_HI: begin
        if (tc != '0) begin
          emit.push_a = 1'b1;
          emit.run_a  = mk_run(wp_e, tc, 8'd0, 8'd0, 8'd0,
                               rspd_pkg::ALPHA_CLEAR, t_end >= PIX_W);
        end
      end
      rspd_pkg::PH_C_HI: begin
        if (word == 16'd0 && end4 && wp_e < PIX_W) begin
          emit.push_a = 1'b1;
          emit.run_a  = mk_run(wp_e, PIX_W - wp_e, 8'd0, 8'd0, 8'd0,
                               rspd_pkg::ALPHA_CLEAR, 1'b1);
        end
      end
      rspd_pkg::PH_BLUE: begin
        emit.push_a = 1'b1;
        emit.run_a  = mk_run(wp_e, WPW'(1), red_r, grn_r, item.data_byte,
                             rspd_pkg::ALPHA_OPAQUE, wp1 >= PIX_W);
        // last pixel of the data: fill the rest in the same step
        if (wp1 < PIX_W && crem_dec == 16'd0 && end3) begin
          emit.push_b = 1'b1;
          emit.run_b  = mk_run(wp1, PIX_W - wp1, 8'd0, 8'd0, 8'd0,
                               rspd_pkg::ALPHA_CLEAR, 1'b1);
        end
      end
      default: ;
    endcase
    if (!step) begin
      emit.push_a = 1'b0;
      emit.push_b = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rspd_pkg::PH_IDLE;
      skip_r  <= 2'd0;
      ds_r    <= 16'd0;
      bc_r    <= '0;
      wp_r    <= '0;
      crem_r  <= 16'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      skip_r  <= skip_nxt;
      ds_r    <= ds_nxt;
      bc_r    <= bc_nxt;
      wp_r    <= wp_nxt;
      crem_r  <= crem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      lo_r  <= lo_nxt;
      red_r <= red_nxt;
      grn_r <= grn_nxt;
    end
  end

  a_done_idles: assert property (@(posedge clk) disable iff (!rst_n)
    (emit.push_a && emit.run_a.sprite_done) |=> (phase_r == rspd_pkg::PH_IDLE))
    else $error("sprite finished but decoder not idle");

  a_second_is_fill: assert property (@(posedge clk) disable iff (!rst_n)
    emit.push_b |-> (emit.push_a && emit.run_b.sprite_done &&
                     emit.run_b.alpha == rspd_pkg::ALPHA_CLEAR))
    else $error("second run is not a closing transparent fill");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != rspd_pkg::PH_IDLE) |-> (wp_r < PIX_W))
    else $error("write position past sprite while decoding");

endmodule

// ----- rtl/rspd_outq.sv -----
module rspd_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rspd_pkg::rspd_emit_t emit,
  input  logic                 pop,
  output rspd_pkg::rspd_out_t  head,
  output logic                 not_empty,
  output logic                 has_room
);

  localparam int QD = 3;

  rspd_pkg::rspd_out_t slot_r [QD];
  rspd_pkg::rspd_out_t slot_nxt [QD];
  logic [1:0] cnt_r, cnt_nxt, base;

  assign base      = cnt_r - {1'b0, pop};
  assign head      = slot_r[0];
  assign not_empty = cnt_r != 2'd0;
  // room for two runs regardless of what the sink does this cycle
  assign has_room  = cnt_r <= 2'd1;

  always_comb begin
    slot_nxt[0] = pop ? slot_r[1] : slot_r[0];
    slot_nxt[1] = pop ? slot_r[2] : slot_r[1];
    slot_nxt[2] = slot_r[2];
    for (int i = 0; i < QD; i++) begin
      if (emit.push_a && base == 2'(i)) slot_nxt[i] = emit.run_a;
      if (emit.push_b && base + 2'd1 == 2'(i)) slot_nxt[i] = emit.run_b;
    end
    cnt_nxt = base + {1'b0, emit.push_a} + {1'b0, emit.push_b};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QD; i++) slot_r[i] <= slot_nxt[i];
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from empty run queue");

  a_room_a: assert property (@(posedge clk) disable iff (!rst_n)
    emit.push_a |-> (base <= 2'd2))
    else $error("run queue overflow");

  a_room_b: assert property (@(posedge clk) disable iff (!rst_n)
    emit.push_b |-> (emit.push_a && base <= 2'd1))
    else $error("run queue overflow on second run");

endmodule
